/* design/kerb_pkg.sv */
// ----------------------------------------------------------------------------
// Keyboard event ring buffer package
// Command codes, field widths and the control and status words that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package kerb_pkg;

	// Field widths fixed by the word formats.
	localparam int CMD_W   = 3;
	localparam int BYTE_W  = 8;
	localparam int WORD_W  = 16;
	localparam int FILL_W  = 5;

	typedef logic [CMD_W-1:0]  cmd_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic [FILL_W-1:0] fill_t;

	// Command codes. Codes above shift status are no-ops.
	localparam cmd_t CMD_KEY_EVENT    = 3'd0;
	localparam cmd_t CMD_PEEK_WORD    = 3'd1;
	localparam cmd_t CMD_POP_WORD     = 3'd2;
	localparam cmd_t CMD_POP_CHAR     = 3'd3;
	localparam cmd_t CMD_SHIFT_STATUS = 3'd4;

	// Controller to datapath.
	typedef struct packed {
		logic accept;       // a request word is taken this cycle
		logic load_direct;  // load the response register from the current request
		logic load_read;    // load the response register from the ring read data
	} kerb_ctrl_t;

	// Datapath to controller.
	typedef struct packed {
		logic need_read;    // the current request reads a held word
	} kerb_stat_t;

endpackage

/* design/kerb_req_if.sv */
// ----------------------------------------------------------------------------
// Keyboard request channel
// Valid/ready channel that carries one command word with its key event.
// ----------------------------------------------------------------------------
interface kerb_req_if;
	import kerb_pkg::*;

	logic  valid;
	logic  ready;
	cmd_t  command;
	logic  is_key_event;
	logic  pressed;
	byte_t key_ascii;
	byte_t key_scan;

	modport source (output valid, output command, output is_key_event, output pressed,
		output key_ascii, output key_scan, input ready);
	modport sink (input valid, input command, input is_key_event, input pressed,
		input key_ascii, input key_scan, output ready);

endinterface

/* design/kerb_rsp_if.sv */
// ----------------------------------------------------------------------------
// Keyboard response channel
// Valid/ready channel that carries one response word per request.
// ----------------------------------------------------------------------------
interface kerb_rsp_if;
	import kerb_pkg::*;

	logic  valid;
	logic  ready;
	word_t read_value;
	logic  was_empty;
	logic  key_available;
	fill_t fill_level;

	modport source (output valid, output read_value, output was_empty,
		output key_available, output fill_level, input ready);
	modport sink (input valid, input read_value, input was_empty,
		input key_available, input fill_level, output ready);

endinterface

/* design/kerb_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kerb_ram #(
	parameter int WIDTH  = 16,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/kerb_ctrl.sv */
// ----------------------------------------------------------------------------
// Keyboard buffer controller
// Sequences each request word through an optional ring read and owns the
// handshakes of both channels.
// ----------------------------------------------------------------------------
module kerb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	input  kerb_pkg::kerb_stat_t stat,
	output kerb_pkg::kerb_ctrl_t ctrl
);
	import kerb_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   accept;

	// In the idle state a new word is taken when the response register is free or drains now.
	assign req_ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;

	// Commands to the datapath.
	always_comb begin
		ctrl.accept      = accept;
		ctrl.load_direct = accept && !stat.need_read;
		ctrl.load_read   = (state_q == ST_READ);
	end

	// State and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (rsp_valid_q && rsp_ready) begin
						rsp_valid_q <= 1'b0;
					end
					if (accept) begin
						if (stat.need_read) begin
							state_q <= ST_READ;
						end else begin
							rsp_valid_q <= 1'b1;
						end
					end
				end
				ST_READ: begin
					// The response register was freed when the word was taken.
					rsp_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* design/kerb_dp.sv */
// ----------------------------------------------------------------------------
// Keyboard buffer datapath
// Ring pointers, held count, key word storage and the response register.
// ----------------------------------------------------------------------------
module kerb_dp #(
	parameter int RING_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kerb_pkg::cmd_t       command,
	input  logic                 is_key_event,
	input  logic                 pressed,
	input  kerb_pkg::byte_t      key_ascii,
	input  kerb_pkg::byte_t      key_scan,
	input  kerb_pkg::kerb_ctrl_t ctrl,
	output kerb_pkg::kerb_stat_t stat,
	output kerb_pkg::word_t      read_value,
	output logic                 was_empty,
	output logic                 key_available,
	output kerb_pkg::fill_t      fill_level
);
	import kerb_pkg::*;

	localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W = $clog2(RING_DEPTH + 1);

	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	cmd_t             cmd_q;

	word_t            key_word;
	word_t            ram_rdata;
	logic             is_read_cmd;
	logic             is_pop_cmd;
	logic             ring_empty;
	logic             ring_full;
	logic             push;
	logic             pop;
	logic [CNT_W+FILL_W-1:0] cnt_ext_d;
	logic [CNT_W+FILL_W-1:0] cnt_ext_q;

	word_t            value_q;
	logic             empty_q;
	logic             avail_q;
	fill_t            fill_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(RING_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	// Decode the request word.
	assign key_word    = {key_scan, key_ascii};
	assign ring_empty  = (cnt_q == '0);
	assign ring_full   = (cnt_q == CNT_W'(RING_DEPTH));
	assign is_pop_cmd  = (command == CMD_POP_WORD) || (command == CMD_POP_CHAR);
	assign is_read_cmd = (command == CMD_PEEK_WORD) || is_pop_cmd;
	assign push        = (command == CMD_KEY_EVENT) && is_key_event && pressed
		&& (key_word != '0);
	assign pop         = is_pop_cmd && !ring_empty;

	assign stat.need_read = is_read_cmd && !ring_empty;

	// Held count after the step. A push into a full ring drops the oldest word.
	always_comb begin
		cnt_d = cnt_q;
		if (push && !ring_full) begin
			cnt_d = cnt_q + 1'b1;
		end else if (pop) begin
			cnt_d = cnt_q - 1'b1;
		end
	end

	assign cnt_ext_d = {{FILL_W{1'b0}}, cnt_d};
	assign cnt_ext_q = {{FILL_W{1'b0}}, cnt_q};

	// Pointers, count and the command of a word waiting on the ring read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			cmd_q    <= CMD_KEY_EVENT;
		end else if (ctrl.accept) begin
			cmd_q <= command;
			cnt_q <= cnt_d;
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
				if (ring_full) begin
					rd_ptr_q <= ptr_next(rd_ptr_q);
				end
			end else if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
		end
	end

	// Key word storage, read at the oldest word.
	kerb_ram #(
		.WIDTH (WORD_W),
		.DEPTH (RING_DEPTH),
		.ADDR_W(PTR_W)
	) u_ram (
		.clk  (clk),
		.we   (ctrl.accept && push),
		.waddr(wr_ptr_q),
		.wdata(key_word),
		.re   (ctrl.accept && stat.need_read),
		.raddr(rd_ptr_q),
		.rdata(ram_rdata)
	);

	// Response register. After a read the count register already holds the
	// level after the step.
	always_ff @(posedge clk) begin
		if (ctrl.load_direct) begin
			value_q <= '0;
			empty_q <= is_read_cmd && ring_empty;
			avail_q <= (cnt_d != '0);
			fill_q  <= cnt_ext_d[FILL_W-1:0];
		end else if (ctrl.load_read) begin
			if (cmd_q == CMD_POP_CHAR) begin
				if (ram_rdata[BYTE_W-1:0] != '0) begin
					value_q <= {{BYTE_W{1'b0}}, ram_rdata[BYTE_W-1:0]};
				end else begin
					value_q <= {{BYTE_W{1'b0}}, ram_rdata[WORD_W-1:BYTE_W]};
				end
			end else begin
				value_q <= ram_rdata;
			end
			empty_q <= 1'b0;
			avail_q <= (cnt_q != '0);
			fill_q  <= cnt_ext_q[FILL_W-1:0];
		end
	end

	assign read_value    = value_q;
	assign was_empty     = empty_q;
	assign key_available = avail_q;
	assign fill_level    = fill_q;

endmodule

/* design/keyboard_event_ring_buffer.sv */
// ----------------------------------------------------------------------------
// Keyboard event ring buffer
// BIOS-style keyboard buffer that overwrites its oldest key word when full.
// ----------------------------------------------------------------------------
// Each request word yields exactly one response word. Key events, shift
// status, no-op codes and any peek or pop on an empty ring load the response
// register: the response appears in the cycle after the request is taken, and
// the next request can be taken in that same cycle. A peek or pop that finds a
// word waits in a read state, as the key words sit in a RAM with registered
// read data; the request side is not ready in that state. A new request is
// taken only while the response register is empty or while its word is taken
// in that same cycle, so a stalled response holds off the requests. The key
// word RAM is not cleared; only written entries are ever read.
module keyboard_event_ring_buffer #(
	parameter int RING_DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	kerb_req_if.sink     req,
	kerb_rsp_if.source   rsp
);
	import kerb_pkg::*;

	kerb_ctrl_t ctrl;
	kerb_stat_t stat;

	// Handshake sequencing.
	kerb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	// Ring storage and response formatting.
	kerb_dp #(
		.RING_DEPTH(RING_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.command      (req.command),
		.is_key_event (req.is_key_event),
		.pressed      (req.pressed),
		.key_ascii    (req.key_ascii),
		.key_scan     (req.key_scan),
		.ctrl         (ctrl),
		.stat         (stat),
		.read_value   (rsp.read_value),
		.was_empty    (rsp.was_empty),
		.key_available(rsp.key_available),
		.fill_level   (rsp.fill_level)
	);

endmodule

/* design/kerb_checker.sv */
// ----------------------------------------------------------------------------
// Keyboard buffer port checker
// Watches the response port of the keyboard buffer for consistent words.
// ----------------------------------------------------------------------------
module kerb_checker #(
	parameter int RING_DEPTH = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input kerb_pkg::word_t       read_value,
	input logic                  was_empty,
	input logic                  key_available,
	input kerb_pkg::fill_t       fill_level
);
	import kerb_pkg::*;

	// A response that is not taken stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response valid dropped before it was taken");

	// The available flag follows the reported level.
	a_avail_level: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (key_available == (fill_level != '0)))
		else $error("key available disagrees with fill level");

	// An empty read returns nothing and reports an empty ring.
	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && was_empty |-> (read_value == '0) && !key_available)
		else $error("empty read returned data or a held word");

	// The level never exceeds the ring depth.
	a_level_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (RING_DEPTH > 31) || (fill_level <= FILL_W'(RING_DEPTH)))
		else $error("fill level above ring depth");

endmodule

bind keyboard_event_ring_buffer kerb_checker #(
	.RING_DEPTH(RING_DEPTH)
) u_kerb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.read_value   (rsp.read_value),
	.was_empty    (rsp.was_empty),
	.key_available(rsp.key_available),
	.fill_level   (rsp.fill_level)
);
